@@ sv/rtd_pkg.sv @@
`timescale 1ns / 1ps

package rtd_pkg;

	// Default sizes
	localparam int INT_BITS_DEF    = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int FRAC_DIGITS_DEF = 6;

	// Output and stack limits
	localparam int MAX_RESULTS = 24;
	localparam int STACK_DEPTH = 16;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

	// Quotient bits retired per cycle by the divider
	localparam int DIV_STEP = 4;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [DIGIT_W-1:0] DIGIT_LETTER_MIN = 6'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_COPY_MIN   = 6'd36;

	localparam logic [CHAR_W-1:0] CH_NONE    = 7'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_DOT     = 7'h2E;

	typedef enum logic {
		UNIT_DIV,
		UNIT_MUL
	} unit_op_t;

	// Saturate a written base into 2..62
	function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) begin
			return RADIX_MIN;
		end
		if (r > RADIX_MAX) begin
			return RADIX_MAX;
		end
		return r;
	endfunction

	// Digits from 36 upwards are written as a capital and one lowercase copy
	function automatic logic digit_has_copy(input logic [DIGIT_W-1:0] d);
		return d >= DIGIT_COPY_MIN;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic lower);
		logic [DIGIT_W-1:0] pos;
		logic [CHAR_W-1:0]  base;
		if (d < DIGIT_LETTER_MIN) begin
			return CH_ZERO + {1'b0, d};
		end
		pos  = (d >= DIGIT_COPY_MIN) ? d - DIGIT_COPY_MIN : d - DIGIT_LETTER_MIN;
		base = lower ? CH_LOWER_A : CH_UPPER_A;
		return base + {1'b0, pos};
	endfunction

endpackage

@@ sv/value_to_radix_digits.sv @@
`timescale 1ns / 1ps

// Fixed-point value to text in a base of 2..62.
// Input stream (s_*): one request per value, integer part and fraction in tdata.
// Output stream (m_*): one character per transfer, tlast on the final character
// of a value, tuser set on the single result sent for a zero value.
// cfg_wr_en/cfg_wr_data write the base; 0 and 1 read as 2, 63 reads as 62.
// Write it only while the block is idle.
// One request is worked at a time and s_tready is low meanwhile.
// Each integer digit is worked out in the shared divider and stacked; each
// stacked digit is then popped and sent one character at a time, then, if a
// fraction is left, the point, then each fraction digit is made by a multiply
// and sent the same way. Once the last integer digit has left the divider,
// the top digit is popped and the first character is registered as soon as
// the output register is free.
// A stalled receiver holds the output register, and the sequencer waits in
// its next output state;
// the next request is taken as soon as the last character is registered.
// Reset clears the sequencer and the output register and sets the base to 10.
// At most 24 characters are sent per value; the 24th then carries tlast.
module value_to_radix_digits #(
	parameter int INT_BITS    = rtd_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS   = rtd_pkg::FRAC_BITS_DEF,
	parameter int FRAC_DIGITS = rtd_pkg::FRAC_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,    // integer_part[15:0], fraction_part[31:16]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,    // char_code[6:0], zero pad[7]
	output logic                          m_tuser,    // empty_res
	output logic                          m_tlast,
	input  logic                          cfg_wr_en,
	input  logic [rtd_pkg::RADIX_W-1:0]   cfg_wr_data
);

	localparam int DIV_W   = ((INT_BITS + rtd_pkg::DIV_STEP - 1) / rtd_pkg::DIV_STEP)
	                         * rtd_pkg::DIV_STEP;
	localparam int DIV_CYC = DIV_W / rtd_pkg::DIV_STEP;
	localparam int DC_W    = $clog2(DIV_CYC + 1);
	localparam int FC_W    = $clog2(FRAC_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_DIV,
		ST_POP,
		ST_EMIT,
		ST_DOT,
		ST_MUL
	} state_t;

	state_t                          st_q;
	logic [rtd_pkg::RADIX_W-1:0]     radix_q;
	logic [DIV_W-1:0]                quot_q;
	logic [FRAC_BITS-1:0]            frac_q;
	logic [rtd_pkg::DIGIT_W-1:0]     rem_q;
	logic [rtd_pkg::DIGIT_W-1:0]     digit_q;
	logic [rtd_pkg::CNT_W-1:0]       cnt_q;
	logic [DC_W-1:0]                 div_cnt_q;
	logic [FC_W-1:0]                 frac_cnt_q;
	logic [rtd_pkg::EMIT_W-1:0]      emit_cnt_q;
	logic                            second_q;
	logic                            m_tvalid_q;
	logic [7:0]                      m_tdata_q;
	logic                            m_tuser_q;
	logic                            m_tlast_q;

	// Input fields, cut to the configured widths
	logic [DIV_W-1:0]                quot_in;
	logic [FRAC_BITS-1:0]            frac_in;

	rtd_pkg::unit_op_t               unit_op;
	logic [DIV_W-1:0]                unit_quot;
	logic [FRAC_BITS-1:0]            unit_frac;
	logic [rtd_pkg::DIGIT_W-1:0]     unit_digit;

	logic                            push;
	logic                            pop;
	logic [rtd_pkg::STACK_AW-1:0]    pop_addr;
	logic [rtd_pkg::DIGIT_W-1:0]     stack_rd;

	logic                            slot_free;
	logic                            div_last;
	logic                            frac_phase;
	logic                            final_digit;
	logic                            final_char;
	logic                            has_copy;
	logic                            cap_hit;
	logic [rtd_pkg::DIGIT_W-1:0]     digit_now;
	logic [rtd_pkg::CHAR_W-1:0]      char_now;

	assign quot_in = DIV_W'(INT_BITS'(s_tdata[15:0]));
	assign frac_in = FRAC_BITS'(s_tdata[31:16]);

	assign unit_op = (st_q == ST_MUL) ? rtd_pkg::UNIT_MUL : rtd_pkg::UNIT_DIV;

	rtd_unit #(
		.DIV_W     (DIV_W),
		.FRAC_BITS (FRAC_BITS)
	) u_unit (
		.op        (unit_op),
		.radix     (radix_q),
		.quot      (quot_q),
		.rem       (rem_q),
		.frac      (frac_q),
		.quot_next (unit_quot),
		.frac_next (unit_frac),
		.digit     (unit_digit)
	);

	// Push on the final divider cycle of each digit; drop digits past the stack depth
	assign div_last = (div_cnt_q == DC_W'(DIV_CYC - 1));
	assign push     = (st_q == ST_DIV) && div_last &&
	                  (cnt_q < rtd_pkg::CNT_W'(rtd_pkg::STACK_DEPTH));
	// Read the top digit in the pop cycle; the stack holds it while it is sent
	assign pop      = (st_q == ST_POP);
	assign pop_addr = rtd_pkg::STACK_AW'(cnt_q - rtd_pkg::CNT_W'(1));

	rtd_stack u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (cnt_q[rtd_pkg::STACK_AW-1:0]),
		.wr_data (unit_digit),
		.rd_en   (pop),
		.rd_addr (pop_addr),
		.rd_data (stack_rd)
	);

	// Output register takes a new character when empty or being drained
	assign slot_free = !m_tvalid_q || m_tready;

	assign frac_phase  = (frac_cnt_q != '0);
	assign final_digit = frac_phase ? (frac_cnt_q == FC_W'(FRAC_DIGITS))
	                                : (cnt_q == '0 && frac_q == '0);
	// Fraction digits come from the multiply, integer digits from the stack
	assign digit_now   = frac_phase ? digit_q : stack_rd;
	assign has_copy    = rtd_pkg::digit_has_copy(digit_now);
	assign final_char  = second_q || !has_copy;
	assign cap_hit     = (emit_cnt_q == rtd_pkg::EMIT_W'(rtd_pkg::MAX_RESULTS - 1));
	assign char_now    = rtd_pkg::digit_char(digit_now, second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			radix_q    <= rtd_pkg::RADIX_RESET;
			cnt_q      <= '0;
			div_cnt_q  <= '0;
			frac_cnt_q <= '0;
			emit_cnt_q <= '0;
			second_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
			quot_q     <= '0;
			frac_q     <= '0;
			rem_q      <= '0;
			digit_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				radix_q <= rtd_pkg::radix_clamp(cfg_wr_data);
			end
			// Drop the held character once taken; a new load below overrides
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						quot_q     <= quot_in;
						frac_q     <= frac_in;
						rem_q      <= '0;
						cnt_q      <= '0;
						div_cnt_q  <= '0;
						frac_cnt_q <= '0;
						emit_cnt_q <= '0;
						second_q   <= 1'b0;
						if (quot_in == '0 && frac_in == '0) begin
							st_q <= ST_ZERO;
						end else if (quot_in != '0) begin
							st_q <= ST_DIV;
						end else begin
							st_q <= ST_DOT;
						end
					end
				end
				ST_ZERO: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, rtd_pkg::CH_NONE};
						m_tuser_q  <= 1'b1;
						m_tlast_q  <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
				ST_DIV: begin
					quot_q    <= unit_quot;
					rem_q     <= unit_digit;
					div_cnt_q <= div_cnt_q + DC_W'(1);
					if (div_last) begin
						div_cnt_q <= '0;
						rem_q     <= '0;
						if (push) begin
							cnt_q <= cnt_q + rtd_pkg::CNT_W'(1);
						end
						if (unit_quot == '0) begin
							st_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					cnt_q <= cnt_q - rtd_pkg::CNT_W'(1);
					st_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, char_now};
						m_tuser_q  <= 1'b0;
						m_tlast_q  <= cap_hit || (final_digit && final_char);
						emit_cnt_q <= emit_cnt_q + rtd_pkg::EMIT_W'(1);
						second_q   <= !final_char;
						if (cap_hit) begin
							st_q <= ST_IDLE;
						end else if (final_char) begin
							if (final_digit) begin
								st_q <= ST_IDLE;
							end else if (frac_phase) begin
								st_q <= ST_MUL;
							end else if (cnt_q != '0) begin
								st_q <= ST_POP;
							end else begin
								st_q <= ST_DOT;
							end
						end
					end
				end
				ST_DOT: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, rtd_pkg::CH_DOT};
						m_tuser_q  <= 1'b0;
						m_tlast_q  <= cap_hit;
						emit_cnt_q <= emit_cnt_q + rtd_pkg::EMIT_W'(1);
						st_q       <= cap_hit ? ST_IDLE : ST_MUL;
					end
				end
				ST_MUL: begin
					frac_q     <= unit_frac;
					digit_q    <= unit_digit;
					frac_cnt_q <= frac_cnt_q + FC_W'(1);
					st_q       <= ST_EMIT;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTH
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("empty result without tlast");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata == 32'd0 |=> st_q == ST_ZERO)
		else $error("zero value did not select the empty result");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= rtd_pkg::EMIT_W'(rtd_pkg::MAX_RESULTS))
		else $error("character count beyond limit");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rtd_pkg::CNT_W'(rtd_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> rem_q < radix_q)
		else $error("partial remainder not below base");
`endif

endmodule

@@ sv/rtd_unit.sv @@
`timescale 1ns / 1ps

// Shared arithmetic: a few restoring-division steps or one fraction multiply.
module rtd_unit #(
	parameter int DIV_W     = 16,
	parameter int FRAC_BITS = rtd_pkg::FRAC_BITS_DEF
) (
	input  rtd_pkg::unit_op_t             op,
	input  logic [rtd_pkg::RADIX_W-1:0]   radix,
	input  logic [DIV_W-1:0]              quot,
	input  logic [rtd_pkg::DIGIT_W-1:0]   rem,
	input  logic [FRAC_BITS-1:0]          frac,
	output logic [DIV_W-1:0]              quot_next,
	output logic [FRAC_BITS-1:0]          frac_next,
	output logic [rtd_pkg::DIGIT_W-1:0]   digit
);

	logic [DIV_W-1:0]                        q;
	logic [rtd_pkg::DIGIT_W-1:0]             rm;
	logic [rtd_pkg::DIGIT_W:0]               trial;
	logic                                    qbit;
	logic [FRAC_BITS+rtd_pkg::RADIX_W-1:0]   prod;

	always_comb begin
		q  = quot;
		rm = rem;
		for (int k = 0; k < rtd_pkg::DIV_STEP; k++) begin
			trial = {rm, q[DIV_W-1]};
			if (trial >= {1'b0, radix}) begin
				rm   = rtd_pkg::DIGIT_W'(trial - {1'b0, radix});
				qbit = 1'b1;
			end else begin
				rm   = trial[rtd_pkg::DIGIT_W-1:0];
				qbit = 1'b0;
			end
			q = {q[DIV_W-2:0], qbit};
		end
		quot_next = q;
	end

	assign prod = {{rtd_pkg::RADIX_W{1'b0}}, frac} * {{FRAC_BITS{1'b0}}, radix};
	assign frac_next = prod[FRAC_BITS-1:0];

	// Remainder is the integer digit; the product's top bits are the fraction digit
	assign digit = (op == rtd_pkg::UNIT_DIV) ? rm : prod[FRAC_BITS +: rtd_pkg::DIGIT_W];

endmodule

@@ sv/rtd_stack.sv @@
`timescale 1ns / 1ps

// Integer digit store, least significant digit at the bottom.
// Read data is registered and held until the next read.
module rtd_stack (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [rtd_pkg::STACK_AW-1:0]   wr_addr,
	input  logic [rtd_pkg::DIGIT_W-1:0]    wr_data,
	input  logic                           rd_en,
	input  logic [rtd_pkg::STACK_AW-1:0]   rd_addr,
	output logic [rtd_pkg::DIGIT_W-1:0]    rd_data
);

	logic [rtd_pkg::DIGIT_W-1:0] stack_q [rtd_pkg::STACK_DEPTH];
	logic [rtd_pkg::DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= stack_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ tb/sv/value_to_radix_digits_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the base register, works out the characters each
// accepted value must give and compares them with what leaves the block.
module value_to_radix_digits_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [31:0]                 s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [7:0]                  m_tdata,
	input  logic                        m_tuser,
	input  logic                        m_tlast,
	input  logic                        cfg_wr_en,
	input  logic [rtd_pkg::RADIX_W-1:0] cfg_wr_data,
	output int                          chars_owed,
	output int                          mismatches
);

	localparam int FRAC_DIGITS = rtd_pkg::FRAC_DIGITS_DEF;
	localparam int SPELL_MAX   = 64;

	typedef struct packed {
		logic [rtd_pkg::CHAR_W-1:0] char_code;
		logic                       empty_res;
		logic                       last;
	} char_rec_t;

	logic [rtd_pkg::RADIX_W-1:0] base_reg;
	char_rec_t                   owed_chars[$];
	logic [rtd_pkg::CHAR_W-1:0]  spelled[SPELL_MAX];
	int                          n_spelled;

	// Append one character to the value being spelled
	function automatic void add_char(input logic [rtd_pkg::CHAR_W-1:0] c);
		if (n_spelled < SPELL_MAX) begin
			spelled[n_spelled] = c;
			n_spelled++;
		end
	endfunction

	// Queue one expected result at the back
	function automatic void owe_char(input char_rec_t rec);
		owed_chars.insert(owed_chars.size(), rec);
	endfunction

	// Append the characters of one digit
	function automatic void spell_digit(input int unsigned d);
		int unsigned pos;
		int unsigned copies;
		if (d <= 9) begin
			add_char(rtd_pkg::CH_ZERO + rtd_pkg::CHAR_W'(d));
			return;
		end
		pos    = (d - 10) % 26;
		copies = (d - 10) / 26;
		add_char(rtd_pkg::CH_UPPER_A + rtd_pkg::CHAR_W'(pos));
		repeat (copies) add_char(rtd_pkg::CH_LOWER_A + rtd_pkg::CHAR_W'(pos));
	endfunction

	// Expected characters of one value in the current base
	function automatic void spell_value(input logic [15:0] int_part,
			input logic [15:0] frac_part);
		int unsigned       r;
		int unsigned       quo;
		int unsigned       frac;
		int unsigned       prod;
		int unsigned       digs[rtd_pkg::STACK_DEPTH];
		int                ndig;
		int                n;
		char_rec_t         rec;
		r = base_reg;
		if (r < rtd_pkg::RADIX_MIN) begin
			r = rtd_pkg::RADIX_MIN;
		end
		if (r > rtd_pkg::RADIX_MAX) begin
			r = rtd_pkg::RADIX_MAX;
		end
		if (int_part == 0 && frac_part == 0) begin
			rec.char_code = rtd_pkg::CH_NONE;
			rec.empty_res = 1'b1;
			rec.last      = 1'b1;
			owe_char(rec);
			return;
		end
		n_spelled = 0;
		quo  = int_part;
		ndig = 0;
		while (quo != 0) begin
			if (ndig < rtd_pkg::STACK_DEPTH) begin
				digs[ndig] = quo % r;
				ndig++;
			end
			quo = quo / r;
		end
		for (int i = ndig - 1; i >= 0; i--) spell_digit(digs[i]);
		if (frac_part != 0) begin
			add_char(rtd_pkg::CH_DOT);
			frac = frac_part;
			for (int i = 0; i < FRAC_DIGITS; i++) begin
				prod = frac * r;
				spell_digit(prod >> 16);
				frac = prod & 32'hFFFF;
			end
		end
		n = (n_spelled > rtd_pkg::MAX_RESULTS) ? rtd_pkg::MAX_RESULTS : n_spelled;
		for (int i = 0; i < n; i++) begin
			rec.char_code = spelled[i];
			rec.empty_res = 1'b0;
			rec.last      = (i == n - 1);
			owe_char(rec);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = rtd_pkg::RADIX_RESET;
			owed_chars.delete();
			n_spelled  = 0;
			mismatches = 0;
			chars_owed <= 0;
		end else begin
			char_rec_t want;
			if (cfg_wr_en) begin
				base_reg = cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				spell_value(s_tdata[15:0], s_tdata[31:16]);
			end
			if (m_tvalid && m_tready) begin
				if (owed_chars.size() == 0) begin
					$error("unexpected character %0h with nothing owed", m_tdata[6:0]);
					mismatches++;
				end else begin
					want = owed_chars.pop_front();
					if (m_tdata[6:0] !== want.char_code) begin
						$error("char_code expected %0h got %0h", want.char_code, m_tdata[6:0]);
						mismatches++;
					end
					if (m_tuser !== want.empty_res) begin
						$error("empty_res expected %0b got %0b", want.empty_res, m_tuser);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("last expected %0b got %0b", want.last, m_tlast);
						mismatches++;
					end
				end
			end
			chars_owed <= owed_chars.size();
		end
	end

endmodule

@@ tb/sv/value_to_radix_digits_tb.sv @@
`timescale 1ns / 1ps

// Drives values into the converter under several bases, lets the receiver
// stall at random and leaves all prediction and comparison to the checker.
module value_to_radix_digits_tb;

	// Worst case is the base-2 conversion with a stall drawn for each of up to
	// 24 characters per request; this leaves several times that for the run.
	localparam int CYCLE_LIMIT     = 500000;
	localparam int ITEMS_PER_PHASE = 21;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [31:0]                 s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [7:0]                  m_tdata;
	logic                        m_tuser;
	logic                        m_tlast;
	logic                        cfg_wr_en;
	logic [rtd_pkg::RADIX_W-1:0] cfg_wr_data;

	int  chars_owed;
	int  mismatches;
	int  cycle_count;
	bit  tx_calm;
	bit  rx_calm;

	value_to_radix_digits u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	value_to_radix_digits_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.chars_owed  (chars_owed),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: draw a stall per character; calm stretches keep tready high
	initial begin
		int stall;
		m_tready <= 1'b0;
		rx_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				rx_calm = !rx_calm;
			end
			stall = rx_calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			// hold tready until a character goes across
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Field values weighted towards zero, one-bit and all-ones corners
	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'(1 << $urandom_range(0, 15));
			2: return 16'hFFFF;
			3: return 16'($urandom_range(1, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one request after a random gap and hold it until accepted.
	// tvalid is only lowered when a gap follows, so a back-to-back request
	// never sees a low and a high scheduled in the same step.
	task automatic send_value(input logic [15:0] int_part, input logic [15:0] frac_part);
		int gap;
		if ($urandom_range(0, 29) == 0) begin
			tx_calm = !tx_calm;
		end
		gap = tx_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {frac_part, int_part};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop tvalid and wait until every owed character has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (chars_owed != 0);
	endtask

	// Change the base only once the block has gone quiet
	task automatic set_radix(input logic [rtd_pkg::RADIX_W-1:0] r);
		drain();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic random_values(input int count);
		repeat (count) send_value(pick_field(), pick_field());
	endtask

	initial begin
		logic [rtd_pkg::RADIX_W-1:0] base_plan[10];
		base_plan = '{6'd16, 6'd0, 6'd1, 6'd63, 6'd36, 6'd37, 6'd8, 6'd60, 6'd3, 6'd11};
		tx_calm     = 1'b0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Base 10 straight out of reset: zero value, corners, lone integer or fraction
		send_value(16'h0000, 16'h0000);
		send_value(16'hFFFF, 16'hFFFF);
		send_value(16'h0001, 16'h0000);
		send_value(16'h0000, 16'h0001);
		send_value(16'h0000, 16'h8000);
		send_value(16'hFFFF, 16'h0000);
		send_value(16'h0000, 16'hFFFF);
		send_value(16'd9,    16'h0000);
		send_value(16'd12345, 16'h2000);
		random_values(ITEMS_PER_PHASE);

		// Base 2: longest string, sixteen integer digits plus the fraction
		set_radix(6'd2);
		send_value(16'hFFFF, 16'hFFFF);
		send_value(16'h8000, 16'h0001);
		random_values(ITEMS_PER_PHASE);

		// Base 62: capitals, and digits from 36 up with their lowercase copy
		set_radix(6'd62);
		send_value(16'd61,   16'h0000);
		send_value(16'd36,   16'h0000);
		send_value(16'd35,   16'h0000);
		send_value(16'd10,   16'h0000);
		send_value(16'd3843, 16'h0000);
		send_value(16'h0000, 16'hFFFF);
		send_value(16'hFFFF, 16'hFFFF);
		send_value(16'h0000, 16'h0000);
		random_values(ITEMS_PER_PHASE);

		// Saturating bases, odd bases and a few drawn at random
		foreach (base_plan[i]) begin
			set_radix(base_plan[i]);
			random_values(ITEMS_PER_PHASE);
		end
		repeat (2) begin
			set_radix(rtd_pkg::RADIX_W'($urandom_range(0, 63)));
			random_values(ITEMS_PER_PHASE);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
